### rtl/core/ctg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ctg_pkg;

  // field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned SubW    = 2;
  localparam int unsigned CountW  = 18;
  localparam int unsigned TargetW = 16;
  localparam int unsigned DelayW  = 32;
  localparam int unsigned CoeffW  = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;

  // delay line length in samples
  localparam int unsigned MaxDelayDefault = 48000;

  // subdivision codes
  localparam logic [SubW-1:0] SubWhole = 2'd0;
  localparam logic [SubW-1:0] SubHalf  = 2'd2;

  // state reset values
  localparam logic [CountW-1:0] CountMax    = 18'h3FFFF;
  localparam logic [CountW-1:0] PeriodReset = 18'd21176;
  localparam logic [DelayW-1:0] DelayReset  = 32'h3E0A_0000;

  // register reset values
  localparam logic [SampleW-1:0] ThrHighReset = 16'd11469;
  localparam logic [SampleW-1:0] ThrLowReset  = 16'd4915;
  localparam logic [CountW-1:0]  MinIntReset  = 18'd2400;
  localparam logic [CountW-1:0]  MaxIntReset  = 18'd144000;
  localparam logic [CoeffW-1:0]  CoeffReset   = 24'd4365;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThrHigh = 3'd0,
    CfgThrLow  = 3'd1,
    CfgMinInt  = 3'd2,
    CfgMaxInt  = 3'd3,
    CfgCoeff   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SampleW-1:0] thr_high;
    logic signed [SampleW-1:0] thr_low;
    logic [CountW-1:0]         min_interval;
    logic [CountW-1:0]         max_interval;
    logic [CoeffW-1:0]         glide_coeff;
  } cfg_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic [SubW-1:0]           subdivision;
  } in_t;

  typedef struct packed {
    logic [CountW-1:0]  tempo_period;
    logic [TargetW-1:0] delay_target;
    logic [DelayW-1:0]  delay_time;
    logic               clock_edge;
    logic               gate_high;
  } out_t;

  // tracker result handed to the glide stage and the result register
  typedef struct packed {
    logic [CountW-1:0] period;
    logic              clock_edge;
    logic              gate_high;
  } trk_t;

endpackage

`default_nettype wire

### rtl/core/ctg_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module ctg_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ctg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ctg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output ctg_pkg::cfg_t                      cfg_o
);

  ctg_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr_high     <= ctg_pkg::ThrHighReset;
      cfg_q.thr_low      <= ctg_pkg::ThrLowReset;
      cfg_q.min_interval <= ctg_pkg::MinIntReset;
      cfg_q.max_interval <= ctg_pkg::MaxIntReset;
      cfg_q.glide_coeff  <= ctg_pkg::CoeffReset;
    end else if (cfg_we_i) begin
      case (ctg_pkg::cfg_idx_e'(cfg_idx_i))
        ctg_pkg::CfgThrHigh: cfg_q.thr_high     <= cfg_wdata_i[ctg_pkg::SampleW-1:0];
        ctg_pkg::CfgThrLow:  cfg_q.thr_low      <= cfg_wdata_i[ctg_pkg::SampleW-1:0];
        ctg_pkg::CfgMinInt:  cfg_q.min_interval <= cfg_wdata_i[ctg_pkg::CountW-1:0];
        ctg_pkg::CfgMaxInt:  cfg_q.max_interval <= cfg_wdata_i[ctg_pkg::CountW-1:0];
        ctg_pkg::CfgCoeff:   cfg_q.glide_coeff  <= cfg_wdata_i;
        default: ;  // unknown index, ignored
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/core/ctg_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

module ctg_tracker (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               advance_i,
  input  wire logic signed [ctg_pkg::SampleW-1:0] sample_i,
  input  wire ctg_pkg::cfg_t                      cfg_i,
  output ctg_pkg::trk_t                           trk_o
);

  logic                       gate_q, gate_d;
  logic [ctg_pkg::CountW-1:0] count_q, count_d, count_inc;
  logic [ctg_pkg::CountW-1:0] period_q, period_d;
  logic                       edge_hit;

  always_comb begin
    count_inc = (count_q == ctg_pkg::CountMax) ? count_q : count_q + 1'b1;
    edge_hit  = !gate_q && ($signed(sample_i) > $signed(cfg_i.thr_high));
    gate_d    = gate_q;
    count_d   = count_inc;
    period_d  = period_q;
    if (edge_hit) begin
      gate_d  = 1'b1;
      count_d = '0;
      // strict window on the measured interval
      if (count_inc > cfg_i.min_interval && count_inc < cfg_i.max_interval) begin
        period_d = count_inc;
      end
    end else if (gate_q && ($signed(sample_i) < $signed(cfg_i.thr_low))) begin
      gate_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q   <= 1'b0;
      count_q  <= '0;
      period_q <= ctg_pkg::PeriodReset;
    end else if (advance_i) begin
      gate_q   <= gate_d;
      count_q  <= count_d;
      period_q <= period_d;
    end
  end

  assign trk_o.period     = period_d;
  assign trk_o.clock_edge = edge_hit;
  assign trk_o.gate_high  = gate_d;

endmodule

`default_nettype wire

### rtl/core/ctg_glide.sv
`timescale 1ns / 1ps
`default_nettype none

module ctg_glide #(
  parameter int unsigned MaxDelay = ctg_pkg::MaxDelayDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              advance_i,
  input  wire logic [ctg_pkg::CountW-1:0]        period_i,
  input  wire logic [ctg_pkg::SubW-1:0]          subdivision_i,
  input  wire logic [ctg_pkg::CoeffW-1:0]        coeff_i,
  output logic      [ctg_pkg::TargetW-1:0]       target_o,
  output logic      [ctg_pkg::DelayW-1:0]        delay_o
);

  localparam int unsigned ProdW = ctg_pkg::DelayW + ctg_pkg::CoeffW;
  localparam logic [ctg_pkg::CountW-1:0] MaxDelayC = ctg_pkg::CountW'(MaxDelay);
  localparam logic [ProdW-1:0] RoundHalf = ProdW'(1) << (ctg_pkg::CoeffW - 1);

  logic [ctg_pkg::DelayW-1:0]  cur_q, cur_d;
  logic [ctg_pkg::CountW+1:0]  three_q;
  logic [ctg_pkg::CountW-1:0]  sub_period;
  logic [ctg_pkg::TargetW-1:0] target;
  logic [ctg_pkg::DelayW-1:0]  tgt_q16, mag, step;
  logic [ProdW-1:0]            prod;
  logic                        rising;

  always_comb begin
    three_q = {2'b00, period_i} + {1'b0, period_i, 1'b0};
    case (subdivision_i)
      ctg_pkg::SubWhole: sub_period = period_i;
      ctg_pkg::SubHalf:  sub_period = period_i >> 1;
      default:           sub_period = three_q[ctg_pkg::CountW+1:2];
    endcase
    target = (sub_period > MaxDelayC) ? ctg_pkg::TargetW'(MaxDelay)
                                      : sub_period[ctg_pkg::TargetW-1:0];
    tgt_q16 = {target, 16'h0000};
    rising  = tgt_q16 >= cur_q;
    mag     = rising ? tgt_q16 - cur_q : cur_q - tgt_q16;
    // round half up, step never exceeds the distance
    prod    = ProdW'(mag) * ProdW'(coeff_i) + RoundHalf;
    step    = prod[ProdW-1:ctg_pkg::CoeffW];
    cur_d   = rising ? cur_q + step : cur_q - step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= ctg_pkg::DelayReset;
    end else if (advance_i) begin
      cur_q <= cur_d;
    end
  end

  assign target_o = target;
  assign delay_o  = cur_d;

endmodule

`default_nettype wire

### rtl/core/clock_tempo_tracker_glide.sv
`timescale 1ns / 1ps
`default_nettype none

// clock tempo tracker with delay-time glide: each input transaction carries one
// audio sample used as a clock signal and a subdivision choice; a schmitt
// trigger turns the sample into a gate, rising gate edges are timed by a
// saturating sample counter, and an interval strictly inside the configured
// window becomes the tempo period. the period, scaled by one, one half or
// three quarters and clamped to MaxDelay, is the delay target, and a one-pole
// glide (q0.24 coefficient) moves the q16.16 delay time toward it. one result
// transaction follows every input transaction. throughput is one transaction
// per clock while the result register is free or being drained; the input
// register holds an accepted item, which then moves through the combinational
// update path (the 32x24 glide multiply with its subtract and add) into the
// result register. the user must write registers through the plain write
// port only while the block is idle; the block itself does not enforce this.
// there is no read-back and no clearing pass after reset.

module clock_tempo_tracker_glide #(
  parameter int unsigned MaxDelay = ctg_pkg::MaxDelayDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [ctg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ctg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire ctg_pkg::in_t                  in_data_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output ctg_pkg::out_t                      out_data_o
);

  ctg_pkg::cfg_t cfg;
  ctg_pkg::trk_t trk;

  // input register
  ctg_pkg::in_t in_q;
  logic         in_valid_q;

  // result register
  ctg_pkg::out_t out_q, out_d;
  logic          out_valid_q;

  logic [ctg_pkg::TargetW-1:0] target;
  logic [ctg_pkg::DelayW-1:0]  delay_next;
  logic                        advance;

  // the held item moves on once the result register is free or being drained;
  // state updates exactly at that move
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  ctg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ctg_tracker u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .sample_i  (in_q.sample),
    .cfg_i     (cfg),
    .trk_o     (trk)
  );

  // target uses the period as updated by this sample
  ctg_glide #(
    .MaxDelay (MaxDelay)
  ) u_glide (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .period_i      (trk.period),
    .subdivision_i (in_q.subdivision),
    .coeff_i       (cfg.glide_coeff),
    .target_o      (target),
    .delay_o       (delay_next)
  );

  always_comb begin
    out_d.tempo_period = trk.period;
    out_d.delay_target = target;
    out_d.delay_time   = delay_next;
    out_d.clock_edge   = trk.clock_edge;
    out_d.gate_high    = trk.gate_high;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // a stalled input register keeps its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input register lost a held transaction");

  // back-pressure only when both stages are occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a full pipeline");

  // an edge always leaves the gate high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clock_edge |-> out_data_o.gate_high)
    else $error("clock edge reported with gate low");

  // target never exceeds the delay line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_data_o.delay_target) <= MaxDelay)
    else $error("delay target beyond delay line length");
`endif

endmodule

`default_nettype wire
